FILE: hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, codes, types and helpers for the quaternion to Euler block.
// ----------------------------------------------------------------------------
package qte_pkg;

    // input word width, Q1.15
    localparam int QUAT_W = 16;

    // pipeline shape
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int FRONT_STAGES = 4;
    localparam int QUO_BITS     = 31;
    localparam int ROOT_BITS    = 31;
    localparam int SQRT_LAT     = ROOT_BITS + 2;
    localparam int ALIGN_LAT    = QUO_BITS + SQRT_LAT;
    localparam int TOTAL_LAT    = FRONT_STAGES + ALIGN_LAT + CORDIC_LAT + 1;

    // datapath widths
    localparam int OPND_W = 36;
    localparam int CW     = 38;
    localparam int ANG_W  = 34;
    localparam int NUM_W  = 33;
    localparam int REM_W  = 34;
    localparam int SREM_W = 35;
    localparam int RAD_W  = 2 * ROOT_BITS;

    // pole codes
    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    // angle constants
    localparam logic signed [ANG_W-1:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [17:0]      PI_Q13     = 18'sd25736;
    localparam logic signed [17:0]      TWO_PI_Q13 = 18'sd51472;

    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    // front end to back end bundle
    typedef struct packed {
        logic [1:0]       pole;
        logic             n_zero;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        opnd_t            pitch_y;
        opnd_t            pitch_x;
        opnd_t            yaw_y;
        opnd_t            yaw_x;
    } front_t;

    // alignment line entry
    typedef struct packed {
        logic             valid;
        logic [1:0]       pole;
        logic             n_zero;
        logic signed [35:0] pitch;
        angle_t           yaw;
    } dly_t;

    // arctangent of 2^-i in Q.30 radians
    function automatic logic [29:0] atan_entry(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314857;
            1:       v = 30'd497837829;
            2:       v = 30'd263043837;
            3:       v = 30'd133525159;
            4:       v = 30'd67021687;
            5:       v = 30'd33543516;
            6:       v = 30'd16775851;
            7:       v = 30'd8388437;
            8:       v = 30'd4194283;
            9:       v = 30'd2097149;
            10:      v = 30'd1048576;
            11:      v = 30'd524288;
            12:      v = 30'd262144;
            13:      v = 30'd131072;
            14:      v = 30'd65536;
            15:      v = 30'd32768;
            16:      v = 30'd16384;
            17:      v = 30'd8192;
            18:      v = 30'd4096;
            19:      v = 30'd2048;
            20:      v = 30'd1024;
            21:      v = 30'd512;
            22:      v = 30'd256;
            23:      v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // round Q.30 radians half up to Q4.13 and clamp to +-lim
    function automatic logic signed [16:0] to_q13(input logic signed [35:0] a,
                                                  input logic signed [17:0] lim);
        logic signed [36:0] sum;
        logic signed [19:0] r;
        logic signed [19:0] lim_e;
        logic signed [16:0] res;
        sum   = $signed({a[35], a}) + 37'sd65536;
        r     = sum[36:17];
        lim_e = {{2{lim[17]}}, lim};
        if (r > lim_e)
            res = lim[16:0];
        else if (r < -lim_e)
            res = -lim[16:0];
        else
            res = r[16:0];
        return res;
    endfunction

endpackage

FILE: hw/rtl/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Products, norm, pole test and CORDIC operand selection in four stages.
// ----------------------------------------------------------------------------
module qte_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_z,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_w,
    output logic                                out_valid,
    output qte_pkg::front_t                     front
);

    // stage 1 products
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, xz_reg;
    logic signed [15:0] y1_reg, w1_reg;
    logic               v1_reg;

    // stage 2 sums
    logic [32:0]        n2_reg, n2_next;
    logic signed [32:0] t2_reg, t2_next;
    logic signed [33:0] py2_reg, py2_next, yy2_reg, yy2_next;
    logic signed [34:0] px2_reg, px2_next, yx2_reg, yx2_next;
    logic signed [32:0] dp_diff, dy_diff;
    logic [31:0]        zx_sum, yx_sum;
    logic signed [15:0] y2_reg, w2_reg;
    logic               v2_reg;

    // stage 3 pole test terms
    logic signed [34:0] d3_reg, d3_next, e3_reg, e3_next;
    logic [40:0]        m3_reg, m3_next;
    logic               nz3_reg, neg3_reg;
    logic [32:0]        num3_reg, num3_next, n3_reg;
    logic signed [32:0] abs_t;
    logic signed [33:0] py3_reg, yy3_reg;
    logic signed [34:0] px3_reg, yx3_reg;
    logic signed [15:0] y3_reg, w3_reg;
    logic               v3_reg;

    // stage 4
    logic signed [64:0] north_sum, south_sum;
    logic               north, south;
    qte_pkg::front_t    front_reg, front_next;
    logic               v4_reg;

    // stage 1: all products
    always_ff @(posedge clk)
    begin
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        ww_reg <= quat_w * quat_w;
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        wy_reg <= quat_w * quat_y;
        xz_reg <= quat_x * quat_z;
        y1_reg <= quat_y;
        w1_reg <= quat_w;
    end

    // stage 2: norm, cross term, atan2 operands for the normal case
    always_comb
    begin
        n2_next  = {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg} + {1'b0, ww_reg};
        t2_next  = $signed({wx_reg[31], wx_reg}) + $signed({yz_reg[31], yz_reg});
        dp_diff  = $signed({wz_reg[31], wz_reg}) - $signed({xy_reg[31], xy_reg});
        dy_diff  = $signed({wy_reg[31], wy_reg}) - $signed({xz_reg[31], xz_reg});
        py2_next = $signed({dp_diff, 1'b0});
        yy2_next = $signed({dy_diff, 1'b0});
        zx_sum   = zz_reg + xx_reg;
        yx_sum   = yy_reg + xx_reg;
        px2_next = 35'sh040000000 - $signed({2'b00, zx_sum, 1'b0});
        yx2_next = 35'sh040000000 - $signed({2'b00, yx_sum, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        n2_reg  <= n2_next;
        t2_reg  <= t2_next;
        py2_reg <= py2_next;
        px2_reg <= px2_next;
        yy2_reg <= yy2_next;
        yx2_reg <= yx2_next;
        y2_reg  <= y1_reg;
        w2_reg  <= w1_reg;
    end

    // stage 3: 2t-n, 2t+n, 107*n and the divider operands
    always_comb
    begin
        d3_next   = $signed({t2_reg, 1'b0}) - $signed({2'b00, n2_reg});
        e3_next   = $signed({t2_reg, 1'b0}) + $signed({2'b00, n2_reg});
        m3_next   = {8'b0, n2_reg} * 41'd107;
        abs_t     = t2_reg[32] ? -t2_reg : t2_reg;
        num3_next = {abs_t[31:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        d3_reg   <= d3_next;
        e3_reg   <= e3_next;
        m3_reg   <= m3_next;
        num3_reg <= num3_next;
        n3_reg   <= n2_reg;
        nz3_reg  <= (n2_reg == '0);
        neg3_reg <= t2_reg[32];
        py3_reg  <= py2_reg;
        px3_reg  <= px2_reg;
        yy3_reg  <= yy2_reg;
        yx3_reg  <= yx2_reg;
        y3_reg   <= y2_reg;
        w3_reg   <= w2_reg;
    end

    // stage 4: pole decision and pitch operand choice
    always_comb
    begin
        north_sum = $signed({d3_reg[34], d3_reg, 29'b0}) + $signed({24'b0, m3_reg});
        south_sum = $signed({e3_reg[34], e3_reg, 29'b0}) - $signed({24'b0, m3_reg});
        north     = !north_sum[64] && (north_sum != '0);
        south     = south_sum[64];

        front_next.n_zero = nz3_reg;
        front_next.neg    = neg3_reg;
        front_next.num    = num3_reg;
        front_next.den    = n3_reg;
        front_next.yaw_y  = {{2{yy3_reg[33]}}, yy3_reg};
        front_next.yaw_x  = {yx3_reg[34], yx3_reg};
        if (north || south)
        begin
            front_next.pole    = north ? qte_pkg::POLE_NORTH : qte_pkg::POLE_SOUTH;
            front_next.pitch_y = {{5{y3_reg[15]}}, y3_reg, 15'b0};
            front_next.pitch_x = {{5{w3_reg[15]}}, w3_reg, 15'b0};
        end
        else
        begin
            front_next.pole    = qte_pkg::POLE_NONE;
            front_next.pitch_y = {{2{py3_reg[33]}}, py3_reg};
            front_next.pitch_x = {px3_reg[34], px3_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign front     = front_reg;

endmodule

FILE: hw/rtl/qte_div.sv
// ----------------------------------------------------------------------------
// qte_div
// Pipelined restoring divider: floor(num * 2^30 / den), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module qte_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [qte_pkg::NUM_W-1:0]          num,
    input  logic [qte_pkg::NUM_W-1:0]          den,
    input  logic                               neg,
    output logic                               out_valid,
    output logic [qte_pkg::QUO_BITS-1:0]       quo,
    output logic                               out_neg
);

    logic [qte_pkg::REM_W-1:0]    rem_reg [qte_pkg::QUO_BITS];
    logic [qte_pkg::QUO_BITS-1:0] quo_reg [qte_pkg::QUO_BITS];
    logic [qte_pkg::NUM_W-1:0]    den_reg [qte_pkg::QUO_BITS];
    logic                         neg_reg [qte_pkg::QUO_BITS];
    logic                         vld_reg [qte_pkg::QUO_BITS];

    for (genvar i = 0; i < qte_pkg::QUO_BITS; i++)
    begin : g_step
        logic [qte_pkg::REM_W-1:0]    rem_in, rem_sh, rem_next;
        logic [qte_pkg::QUO_BITS-1:0] quo_in, quo_next;
        logic [qte_pkg::NUM_W-1:0]    den_in;
        logic                         neg_in, vld_in, ge;

        if (i == 0)
        begin : g_head
            assign rem_in = {1'b0, num};
            assign quo_in = '0;
            assign den_in = den;
            assign neg_in = neg;
            assign vld_in = in_valid;
            assign rem_sh = rem_in;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign vld_in = vld_reg[i-1];
            assign rem_sh = {rem_in[qte_pkg::REM_W-2:0], 1'b0};
        end

        // trial subtract
        assign ge       = (rem_sh >= {1'b0, den_in});
        assign rem_next = ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
        assign quo_next = {quo_in[qte_pkg::QUO_BITS-2:0], ge};

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            quo_reg[i] <= quo_next;
            den_reg[i] <= den_in;
            neg_reg[i] <= neg_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_in;
        end
    end

    assign out_valid = vld_reg[qte_pkg::QUO_BITS-1];
    assign quo       = quo_reg[qte_pkg::QUO_BITS-1];
    assign out_neg   = neg_reg[qte_pkg::QUO_BITS-1];

endmodule

FILE: hw/rtl/qte_sqrt.sv
// ----------------------------------------------------------------------------
// qte_sqrt
// Cosine leg for asin: floor(sqrt(2^60 - s*s)), one root bit per stage.
// ----------------------------------------------------------------------------
module qte_sqrt
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [qte_pkg::QUO_BITS-1:0]       quo,
    input  logic                               neg,
    output logic                               out_valid,
    output qte_pkg::opnd_t                     sin_op,
    output qte_pkg::opnd_t                     cos_op
);

    localparam int RB = qte_pkg::ROOT_BITS;

    // square and radicand stages
    logic [2*qte_pkg::QUO_BITS-1:0] sq_full;
    logic [60:0]                    sq_reg;
    logic [qte_pkg::RAD_W-1:0]      rad_reg;
    logic [qte_pkg::QUO_BITS-1:0]   qm_reg, qr_reg;
    logic                           nm_reg, nr_reg, vm_reg, vr_reg;

    // root stages
    logic [qte_pkg::SREM_W-1:0]   rem_reg  [RB];
    logic [RB-1:0]                root_reg [RB];
    logic [qte_pkg::RAD_W-1:0]    radp_reg [RB];
    logic [qte_pkg::QUO_BITS-1:0] quo_reg  [RB];
    logic                         neg_reg  [RB];
    logic                         vld_reg  [RB];

    assign sq_full = {{qte_pkg::QUO_BITS{1'b0}}, quo} * {{qte_pkg::QUO_BITS{1'b0}}, quo};

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_full[60:0];
        qm_reg  <= quo;
        nm_reg  <= neg;
        rad_reg <= (62'd1 << 60) - {1'b0, sq_reg};
        qr_reg  <= qm_reg;
        nr_reg  <= nm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else
        begin
            vm_reg <= in_valid;
            vr_reg <= vm_reg;
        end
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_step
        logic [qte_pkg::SREM_W-1:0]   rem_in, rem_sh, trial, rem_next;
        logic [RB-1:0]                root_in, root_next;
        logic [qte_pkg::RAD_W-1:0]    rad_in;
        logic [qte_pkg::QUO_BITS-1:0] quo_in;
        logic                         neg_in, vld_in, ge;

        if (k == 0)
        begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad_reg;
            assign quo_in  = qr_reg;
            assign neg_in  = nr_reg;
            assign vld_in  = vr_reg;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = radp_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // bring down the next bit pair and try 4*root+1
        assign rem_sh    = {rem_in[qte_pkg::SREM_W-3:0], rad_in[qte_pkg::RAD_W-1-2*k -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[RB-2:0], ge};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            radp_reg[k] <= rad_in;
            quo_reg[k]  <= quo_in;
            neg_reg[k]  <= neg_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_in;
        end
    end

    // signed sine and cosine operands
    assign out_valid = vld_reg[RB-1];
    assign sin_op    = neg_reg[RB-1]
                     ? -$signed({5'b0, quo_reg[RB-1]})
                     :  $signed({5'b0, quo_reg[RB-1]});
    assign cos_op    = $signed({5'b0, root_reg[RB-1]});

endmodule

FILE: hw/rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q.30 radians.
// ----------------------------------------------------------------------------
module qte_cordic
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  qte_pkg::opnd_t     y_in,
    input  qte_pkg::opnd_t     x_in,
    output logic               out_valid,
    output qte_pkg::angle_t    angle
);

    localparam int N = qte_pkg::CORDIC_STEPS;

    logic signed [qte_pkg::CW-1:0] x_reg [N+1];
    logic signed [qte_pkg::CW-1:0] y_reg [N+1];
    qte_pkg::angle_t               z_reg [N+1];
    logic                          zero_reg [N+1];
    logic                          vld_reg  [N+1];

    logic signed [qte_pkg::CW-1:0] xe, ye, x0_next, y0_next;
    qte_pkg::angle_t               z0_next;

    // fold the left half plane onto the right
    always_comb
    begin
        xe = {{2{x_in[qte_pkg::OPND_W-1]}}, x_in};
        ye = {{2{y_in[qte_pkg::OPND_W-1]}}, y_in};
        if (x_in < 0)
        begin
            x0_next = -xe;
            y0_next = -ye;
            z0_next = (y_in >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
        end
        else
        begin
            x0_next = xe;
            y0_next = ye;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        zero_reg[0] <= (x_in == 0) && (y_in == 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    // micro-rotations
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [qte_pkg::CW-1:0] dx, dy, x_next, y_next;
        qte_pkg::angle_t               step, z_next;

        assign dx   = y_reg[i] >>> i;
        assign dy   = x_reg[i] >>> i;
        assign step = $signed({4'b0, qte_pkg::atan_entry(i)});

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + step;
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - step;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            zero_reg[i+1] <= zero_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end
    end

    assign out_valid = vld_reg[N];
    assign angle     = zero_reg[N] ? '0 : z_reg[N];

endmodule

FILE: hw/rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Quaternion (Q1.15) to three Euler angles (Q4.13 radians) with pole handling.
// ----------------------------------------------------------------------------
// Fully pipelined: a new word may be given on start in every cycle, busy
// stays low, and each result appears on done for one cycle. The roll path
// is the longest: a four stage front end, a 31 stage divider for 2T/N,
// a 33 stage square root for the cosine leg and a 17 stage CORDIC, then
// one output register. Pitch and yaw CORDICs run early and wait in an
// alignment line. The receiver cannot stall, so every result must be
// taken in the cycle it is shown.
module quaternion_to_euler
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [qte_pkg::QUAT_W-1:0]  quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0]  quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0]  quat_z,
    input  logic signed [qte_pkg::QUAT_W-1:0]  quat_w,
    output logic                               done,
    output logic signed [16:0]                 angle_pitch,
    output logic signed [15:0]                 angle_roll,
    output logic signed [15:0]                 angle_yaw,
    output logic [1:0]                         pole_case
);

    qte_pkg::front_t              front;
    logic                         front_vld;
    logic                         div_vld, div_neg;
    logic [qte_pkg::QUO_BITS-1:0] div_quo;
    logic                         sq_vld;
    qte_pkg::opnd_t               sin_op, cos_op;
    logic                         pitch_vld, yaw_vld, roll_vld;
    qte_pkg::angle_t              pitch_ang, yaw_ang, roll_ang;

    logic [2:0]                   side_reg [qte_pkg::CORDIC_LAT];
    qte_pkg::dly_t                dly_reg  [qte_pkg::ALIGN_LAT];
    qte_pkg::dly_t                dly_next, tail;

    logic signed [16:0]           pitch_q, roll_q, yaw_q;
    logic signed [16:0]           pitch_next;
    logic signed [15:0]           roll_next, yaw_next;
    logic signed [16:0]           pitch_reg;
    logic signed [15:0]           roll_reg, yaw_reg;
    logic [1:0]                   pole_reg;
    logic                         done_reg;

    assign busy = 1'b0;

    qte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .out_valid (front_vld),
        .front     (front)
    );

    qte_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_vld),
        .num       (front.num),
        .den       (front.den),
        .neg       (front.neg),
        .out_valid (div_vld),
        .quo       (div_quo),
        .out_neg   (div_neg)
    );

    qte_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_vld),
        .quo       (div_quo),
        .neg       (div_neg),
        .out_valid (sq_vld),
        .sin_op    (sin_op),
        .cos_op    (cos_op)
    );

    qte_cordic u_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .y_in      (sin_op),
        .x_in      (cos_op),
        .out_valid (roll_vld),
        .angle     (roll_ang)
    );

    qte_cordic u_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_vld),
        .y_in      (front.pitch_y),
        .x_in      (front.pitch_x),
        .out_valid (pitch_vld),
        .angle     (pitch_ang)
    );

    qte_cordic u_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_vld),
        .y_in      (front.yaw_y),
        .x_in      (front.yaw_x),
        .out_valid (yaw_vld),
        .angle     (yaw_ang)
    );

    // pole code and zero flag follow the pitch and yaw CORDICs
    always_ff @(posedge clk)
    begin
        side_reg[0] <= {front.pole, front.n_zero};
        for (int k = 1; k < qte_pkg::CORDIC_LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // scale pitch at the poles, then wait for the roll path
    always_comb
    begin
        dly_next.valid  = pitch_vld;
        dly_next.pole   = side_reg[qte_pkg::CORDIC_LAT-1][2:1];
        dly_next.n_zero = side_reg[qte_pkg::CORDIC_LAT-1][0];
        dly_next.yaw    = yaw_ang;
        case (dly_next.pole)
            qte_pkg::POLE_NORTH: dly_next.pitch = $signed({pitch_ang[33], pitch_ang, 1'b0});
            qte_pkg::POLE_SOUTH: dly_next.pitch = -$signed({pitch_ang[33], pitch_ang, 1'b0});
            default:             dly_next.pitch = {{2{pitch_ang[33]}}, pitch_ang};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < qte_pkg::ALIGN_LAT; k++)
                dly_reg[k] <= '0;
        end
        else
        begin
            dly_reg[0] <= dly_next;
            for (int k = 1; k < qte_pkg::ALIGN_LAT; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    assign tail = dly_reg[qte_pkg::ALIGN_LAT-1];

    // final rounding and pole overrides
    always_comb
    begin
        pitch_q = qte_pkg::to_q13(tail.pitch, qte_pkg::TWO_PI_Q13);
        roll_q  = qte_pkg::to_q13({{2{roll_ang[33]}}, roll_ang}, qte_pkg::PI_Q13);
        yaw_q   = qte_pkg::to_q13({{2{tail.yaw[33]}}, tail.yaw}, qte_pkg::PI_Q13);

        pitch_next = tail.n_zero ? '0 : pitch_q;
        case (tail.pole)
            qte_pkg::POLE_NORTH:
            begin
                roll_next = qte_pkg::PI_Q13[15:0];
                yaw_next  = '0;
            end
            qte_pkg::POLE_SOUTH:
            begin
                roll_next = -qte_pkg::PI_Q13[15:0];
                yaw_next  = '0;
            end
            default:
            begin
                roll_next = tail.n_zero ? '0 : roll_q[15:0];
                yaw_next  = tail.n_zero ? '0 : yaw_q[15:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pitch_reg <= pitch_next;
        roll_reg  <= roll_next;
        yaw_reg   <= yaw_next;
        pole_reg  <= tail.pole;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= roll_vld;
    end

    assign done        = done_reg;
    assign angle_pitch = pitch_reg;
    assign angle_roll  = roll_reg;
    assign angle_yaw   = yaw_reg;
    assign pole_case   = pole_reg;

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(qte_pkg::TOTAL_LAT) done)
        else $error("result missing after fixed latency");

    // roll path and alignment line stay in step
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        roll_vld == tail.valid)
        else $error("roll path out of step with alignment line");

    // pitch and yaw CORDICs run together
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_vld == yaw_vld)
        else $error("pitch and yaw CORDICs out of step");

    // pole results carry zero yaw and full-scale roll
    a_pole: assert property (@(posedge clk) disable iff (!rst_n)
        done && (pole_case == qte_pkg::POLE_NORTH || pole_case == qte_pkg::POLE_SOUTH)
        |-> (angle_yaw == 16'sd0) &&
            (angle_roll == 16'sd25736 || angle_roll == -16'sd25736))
        else $error("pole result with wrong roll or yaw");

endmodule

FILE: tb/quaternion_to_euler_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_tb
// Self-checking bench for the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
// A directed table walks zero, identity, axis, pole, near-pole and extreme
// words. Random words follow: mostly unit quaternions, some pole-leaning
// words and some raw full-range noise. A bit-true predictor computes the
// expected result of every word but the zero word, whose result is given;
// results are compared in order as done pulses. Sender gaps change by phase.
// ----------------------------------------------------------------------------
module quaternion_to_euler_tb;

    localparam int  N_RANDOM  = 1380;
    localparam int  DRAIN_CYC = 200;
    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam longint HALF_Q30 = 64'sd1 << 29;
    localparam longint EPS_Q30  = 64'sd107;
    localparam longint PI_RAD30 = 64'sd3373259426;

    typedef struct packed {
        logic signed [16:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic [1:0]         pole;
    } euler_t;

    typedef struct {
        logic signed [15:0] x, y, z, w;
        bit                 typed;
        euler_t             res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic               done;
    logic signed [16:0] angle_pitch;
    logic signed [15:0] angle_roll;
    logic signed [15:0] angle_yaw;
    logic [1:0]         pole_case;

    euler_t euler_q[$];
    int     fail_cnt;
    int     word_cnt;
    int     pole_cnt[3];

    quaternion_to_euler DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .quat_w      (quat_w),
        .done        (done),
        .angle_pitch (angle_pitch),
        .angle_roll  (angle_roll),
        .angle_yaw   (angle_yaw),
        .pole_case   (pole_case)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // arctangent table in Q.30 radians
    function automatic longint atan_step(input int i);
        longint tbl[16];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                262144, 131072, 65536, 32768};
        return tbl[i];
    endfunction

    // integer floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // vectoring cordic arctangent, Q.30 radians
    function automatic longint vec_atan2(input longint yv, input longint xv);
        longint base;
        longint acc;
        longint dx;
        longint dy;
        base = 0;
        acc  = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            base = (yv >= 0) ? PI_RAD30 : -PI_RAD30;
            xv   = -xv;
            yv   = -yv;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv  += dx;
                yv  -= dy;
                acc += atan_step(i);
            end
            else
            begin
                xv  -= dx;
                yv  += dy;
                acc -= atan_step(i);
            end
        end
        return base + acc;
    endfunction

    // round half up to Q4.13 and clamp
    function automatic longint round_q13(input longint a, input longint lim);
        longint r;
        r = (a + (64'sd1 << 16)) >>> 17;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    // expected angles and pole code for one quaternion
    function automatic euler_t quat_angles(input logic signed [15:0] qx, qy, qz, qw);
        longint x, y, z, w, x2, y2, z2, w2, nrm, t, adbc, acbd, s, c, pi13, two_pi13;
        longint unsigned ss, sq;
        euler_t e;
        x = qx; y = qy; z = qz; w = qw;
        x2 = x * x; y2 = y * y; z2 = z * z; w2 = w * w;
        nrm      = w2 + x2 + y2 + z2;
        t        = w * x + y * z;
        pi13     = qte_pkg::PI_Q13;
        two_pi13 = qte_pkg::TWO_PI_Q13;
        if (t * ONE_Q30 > (HALF_Q30 - EPS_Q30) * nrm)
        begin
            e.pitch = 17'(round_q13(2 * vec_atan2(y * 32768, w * 32768), two_pi13));
            e.roll  = 16'(pi13);
            e.yaw   = 0;
            e.pole  = qte_pkg::POLE_NORTH;
        end
        else if (t * ONE_Q30 < (-HALF_Q30 + EPS_Q30) * nrm)
        begin
            e.pitch = 17'(round_q13(-2 * vec_atan2(y * 32768, w * 32768), two_pi13));
            e.roll  = 16'(-pi13);
            e.yaw   = 0;
            e.pole  = qte_pkg::POLE_SOUTH;
        end
        else
        begin
            adbc    = w * z - x * y;
            acbd    = w * y - x * z;
            e.pole  = qte_pkg::POLE_NONE;
            e.pitch = 17'(round_q13(vec_atan2(2 * adbc, ONE_Q30 - 2 * (z2 + x2)),
                                    two_pi13));
            e.yaw   = 16'(round_q13(vec_atan2(2 * acbd, ONE_Q30 - 2 * (y2 + x2)), pi13));
            if (nrm == 0)
            begin
                e.pitch = 0;
                e.roll  = 0;
                e.yaw   = 0;
            end
            else
            begin
                s  = (2 * t * ONE_Q30) / nrm;
                ss = (s < 0) ? -s : s;
                sq = ss * ss;
                c  = (sq >= (64'd1 << 60)) ? 0 : floor_sqrt((64'd1 << 60) - sq);
                e.roll = 16'(round_q13(vec_atan2(s, c), pi13));
            end
        end
        return e;
    endfunction

    // hand one word to the block, then maybe leave a gap
    task automatic send_word(input logic signed [15:0] qx, qy, qz, qw,
                             input bit typed, input euler_t res, input int gap_pct);
        euler_t e;
        start  <= 1'b1;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e = typed ? res : quat_angles(qx, qy, qz, qw);
        euler_q.push_back(e);
        pole_cnt[e.pole]++;
        word_cnt++;
        // each following cycle is idle with the phase's probability
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
    endtask

    // random unit quaternion, scaled a little under one, or to 0.1 to 1 of that
    task automatic unit_quat(output logic signed [15:0] qx, qy, qz, qw);
        real a[4];
        real mag;
        real amp;
        mag = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = ($urandom_range(65535) - 32767.5) / 32768.0;
            mag += a[i] * a[i];
        end
        mag = $sqrt(mag);
        if (mag < 1.0e-3)
            mag = 1.0;
        amp = 32767.0 * ($urandom_range(1) ? 1.0 : $urandom_range(100, 1000) / 1000.0);
        qx = 16'($rtoi(a[0] / mag * amp));
        qy = 16'($rtoi(a[1] / mag * amp));
        qz = 16'($rtoi(a[2] / mag * amp));
        qw = 16'($rtoi(a[3] / mag * amp));
    endtask

    // result checker, results arrive one per done pulse
    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && done)
        begin
            if (euler_q.size() == 0)
            begin
                $error("unexpected result word: pitch %0d roll %0d yaw %0d pole %0d",
                       angle_pitch, angle_roll, angle_yaw, pole_case);
                fail_cnt++;
            end
            else
            begin
                e = euler_q.pop_front();
                if (angle_pitch !== e.pitch)
                begin
                    $error("angle_pitch: expected %0d, got %0d", e.pitch, angle_pitch);
                    fail_cnt++;
                end
                if (angle_roll !== e.roll)
                begin
                    $error("angle_roll: expected %0d, got %0d", e.roll, angle_roll);
                    fail_cnt++;
                end
                if (angle_yaw !== e.yaw)
                begin
                    $error("angle_yaw: expected %0d, got %0d", e.yaw, angle_yaw);
                    fail_cnt++;
                end
                if (pole_case !== e.pole)
                begin
                    $error("pole_case: expected %0d, got %0d", e.pole, pole_case);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        euler_t zero_res;
        int gap_pct[4];
        int kind;
        logic signed [15:0] qx, qy, qz, qw;
        int wait_cyc;

        fail_cnt = 0;
        word_cnt = 0;
        pole_cnt = '{0, 0, 0};
        rst_n  = 1'b0;
        start  = 1'b0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quat_w = '0;
        zero_res = '{pitch: 0, roll: 0, yaw: 0, pole: qte_pkg::POLE_NONE};
        // the receiver cannot stall; phases 0 and 2 run with no sender gaps
        gap_pct  = '{0, 53, 0, 8};

        // directed words: zero word has an obvious answer, the rest are predicted
        rows = '{
            '{0, 0, 0, 0, 1, zero_res},
            '{0, 0, 0, 32767, 0, zero_res},
            '{0, 0, 0, -32768, 0, zero_res},
            '{32767, 0, 0, 0, 0, zero_res},
            '{-32768, 0, 0, 0, 0, zero_res},
            '{0, 32767, 0, 0, 0, zero_res},
            '{0, 0, 32767, 0, 0, zero_res},
            '{0, -32768, 0, 0, 0, zero_res},
            '{23170, 0, 0, 23170, 0, zero_res},
            '{-23170, 0, 0, 23170, 0, zero_res},
            '{23170, 0, 0, -23170, 0, zero_res},
            '{16384, 16384, 16384, 16384, 0, zero_res},
            '{-16384, 16384, -16384, 16384, 0, zero_res},
            '{23170, 5, 5, 23170, 0, zero_res},
            '{23170, 3, -3, 23169, 0, zero_res},
            '{23000, 100, 100, 23340, 0, zero_res},
            '{32767, 32767, 32767, 32767, 0, zero_res},
            '{-32768, -32768, -32768, -32768, 0, zero_res},
            '{-32768, 32767, -32768, 32767, 0, zero_res},
            '{1, 0, 0, 1, 0, zero_res},
            '{1, 1, -1, 2, 0, zero_res},
            '{0, 0, 1, 0, 0, zero_res},
            '{21845, 0, 21845, 0, 0, zero_res},
            '{12345, -23456, 4321, -6789, 0, zero_res}
        };

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].x, rows[i].y, rows[i].z, rows[i].w,
                      rows[i].typed, rows[i].res, 0);

        // random phases, each with its own sender gap rate
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                kind = $urandom_range(99);
                if (kind < 60)
                    unit_quat(qx, qy, qz, qw);
                else if (kind < 80)
                begin
                    // words close to a pole, either sign
                    qx = 16'($urandom_range(12000, 23170));
                    qw = 16'(qx + $signed($urandom_range(40)) - 20);
                    qy = 16'($signed($urandom_range(400)) - 200);
                    qz = 16'($signed($urandom_range(400)) - 200);
                    if ($urandom_range(1))
                        qx = -qx;
                end
                else
                begin
                    qx = 16'($urandom);
                    qy = 16'($urandom);
                    qz = 16'($urandom);
                    qw = 16'($urandom);
                end
                send_word(qx, qy, qz, qw, 0, zero_res, gap_pct[ph]);
            end
            // hold off until the pipeline is empty
            start <= 1'b0;
            wait_cyc = 0;
            while (euler_q.size() != 0 && wait_cyc < 2000)
            begin
                @(posedge clk);
                wait_cyc++;
            end
        end

        start <= 1'b0;
        wait_cyc = 0;
        while (euler_q.size() != 0 && wait_cyc < 2000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC)
            @(posedge clk);

        $display("covered %0d words: %0d normal, %0d north pole, %0d south pole",
                 word_cnt, pole_cnt[0], pole_cnt[1], pole_cnt[2]);
        $display("sender gap rates of 0, 53 and 8 percent, with full drains in between");
        if (fail_cnt == 0 && euler_q.size() == 0)
            $display("tb: success");
        else
        begin
            if (euler_q.size() != 0)
                $error("%0d expected results never arrived", euler_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/qte_pkg.sv
hw/rtl/qte_front.sv
hw/rtl/qte_div.sv
hw/rtl/qte_sqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
